@@ rtl/sacc_pkg.sv @@
`timescale 1ns / 1ps

package sacc_pkg;

    localparam int ADDR_W          = 32;
    localparam int WORD_W          = 32;
    localparam int STAMP_W         = 32;
    localparam int COUNT_W         = 32;
    localparam int WAY_IDX_W       = 4;    // wide enough for up to 16 ways
    localparam int WAY_OUT_W       = 2;
    localparam int LINE_OFF_OUT_W  = 4;
    localparam int LINE_ADDR_OUT_W = 28;

    localparam int DEF_WAYS        = 4;
    localparam int DEF_INDEX_BITS  = 4;
    localparam int DEF_OFFSET_BITS = 4;

    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 1;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK     = 1'b1;

    // Result of the tag compare and replacement choice for one set.
    typedef struct packed {
        logic                 hit;
        logic [WAY_IDX_W-1:0] hit_way;
        logic [WAY_IDX_W-1:0] victim_way;
    } t_lookup;

endpackage

@@ rtl/set_assoc_cache_controller.sv @@
`timescale 1ns / 1ps

// Tag and replacement controller of a set-associative cache, LRU by
// last-use stamps, write-back or write-through, write-allocate or not.
// Access channel: i_valid / o_ready carry one word of operation, address
// and write word. Result channel: o_valid / i_ready carry hit, way, victim
// writeback, fill request, memory word write and the running hit count.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 write_allocate_mode, 1 write_back_mode); both reset to 1.
// Timing: the accept edge registers the access and reads the set's tag and
// stamp row from the set memory. A later edge, when the result register
// is empty or being taken, writes the updated row back (not on a
// no-allocate write miss) and loads the result register. For this
// read-modify-write o_ready stays low while the access is in flight.
// Stall: when the result register is full and i_ready is low, the access
// in flight holds (no state update) and o_ready stays low until the
// result word is taken.
// Reset: valid and dirty bits (flip-flops) clear at once, use clock and hit
// count go to zero; the tag and stamp memories need no clearing pass.
module set_assoc_cache_controller #(
    parameter int WAYS        = sacc_pkg::DEF_WAYS,
    parameter int INDEX_BITS  = sacc_pkg::DEF_INDEX_BITS,
    parameter int OFFSET_BITS = sacc_pkg::DEF_OFFSET_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_operation,
    input  logic [sacc_pkg::ADDR_W-1:0]           i_address,
    input  logic [sacc_pkg::WORD_W-1:0]           i_write_word,
    input  logic                                  i_cfg_we,
    input  logic [sacc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sacc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_hit,
    output logic [sacc_pkg::WAY_OUT_W-1:0]        o_way_used,
    output logic [sacc_pkg::LINE_OFF_OUT_W-1:0]   o_line_offset,
    output logic                                  o_evict,
    output logic [sacc_pkg::LINE_ADDR_OUT_W-1:0]  o_evict_line_address,
    output logic                                  o_fill,
    output logic                                  o_mem_write,
    output logic [sacc_pkg::ADDR_W-1:0]           o_mem_write_address,
    output logic [sacc_pkg::WORD_W-1:0]           o_mem_write_data,
    output logic [sacc_pkg::COUNT_W-1:0]          o_hit_count
);

    localparam int SETS      = 1 << INDEX_BITS;
    localparam int SET_W     = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int TAG_SHIFT = INDEX_BITS + OFFSET_BITS;
    localparam int TAG_W     = sacc_pkg::ADDR_W - TAG_SHIFT;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);

    // config
    logic r_wa;
    logic r_wb;

    // access in flight
    logic                        r_b_valid;
    logic                        r_op;
    logic [sacc_pkg::ADDR_W-1:0] r_addr;
    logic [sacc_pkg::WORD_W-1:0] r_word;

    // set memories and registered read row
    logic [WAYS-1:0][TAG_W-1:0]             r_tag_mem   [SETS];
    logic [WAYS-1:0][sacc_pkg::STAMP_W-1:0] r_stamp_mem [SETS];
    logic [WAYS-1:0][TAG_W-1:0]             r_tag_row;
    logic [WAYS-1:0][sacc_pkg::STAMP_W-1:0] r_stamp_row;

    logic [WAYS-1:0] r_valid [SETS];
    logic [WAYS-1:0] r_dirty [SETS];

    logic [sacc_pkg::STAMP_W-1:0] r_clock;
    logic [sacc_pkg::COUNT_W-1:0] r_hits;

    // result register
    logic                                  r_out_valid;
    logic                                  r_hit;
    logic [sacc_pkg::WAY_OUT_W-1:0]        r_way_used;
    logic [sacc_pkg::LINE_OFF_OUT_W-1:0]   r_line_offset;
    logic                                  r_evict;
    logic [sacc_pkg::LINE_ADDR_OUT_W-1:0]  r_evict_addr;
    logic                                  r_fill;
    logic                                  r_mw;
    logic [sacc_pkg::ADDR_W-1:0]           r_mw_addr;
    logic [sacc_pkg::WORD_W-1:0]           r_mw_data;

    logic                                   in_fire;
    logic                                   b_fire;
    logic [SET_W-1:0]                       in_set;
    logic [SET_W-1:0]                       b_set;
    logic [TAG_W-1:0]                       b_tag;
    logic [WAYS-1:0]                        b_valid_ways;
    logic [WAYS-1:0]                        b_dirty_ways;
    sacc_pkg::t_lookup                      look;
    logic                                   b_write;
    logic                                   b_noalloc;
    logic                                   b_fill;
    logic [WAY_W-1:0]                       b_way;
    logic [WAY_W-1:0]                       b_victim;
    logic                                   b_evict;
    logic [sacc_pkg::ADDR_W-1:0]            b_victim_line;
    logic                                   b_mw;
    logic [sacc_pkg::STAMP_W-1:0]           n_clock;
    logic [sacc_pkg::COUNT_W-1:0]           n_hits;
    logic [WAYS-1:0][TAG_W-1:0]             n_tag_row;
    logic [WAYS-1:0][sacc_pkg::STAMP_W-1:0] n_stamp_row;

    assign o_ready = !r_b_valid;
    assign in_fire = i_valid && o_ready;
    assign b_fire  = r_b_valid && (!r_out_valid || i_ready);

    assign in_set = SET_W'(i_address >> OFFSET_BITS) & SET_MASK;
    assign b_set  = SET_W'(r_addr >> OFFSET_BITS) & SET_MASK;
    assign b_tag  = TAG_W'(r_addr >> TAG_SHIFT);

    assign b_valid_ways = r_valid[b_set];
    assign b_dirty_ways = r_dirty[b_set];

    sacc_lookup #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W)
    ) u_lookup (
        .i_tags       (r_tag_row),
        .i_stamps     (r_stamp_row),
        .i_valid_ways (b_valid_ways),
        .i_tag        (b_tag),
        .o_look       (look)
    );

    assign b_write   = (r_op == sacc_pkg::OP_WRITE);
    assign b_noalloc = !look.hit && b_write && !r_wa;
    assign b_fill    = !look.hit && !b_noalloc;
    assign b_victim  = look.victim_way[WAY_W-1:0];
    assign b_way     = look.hit ? look.hit_way[WAY_W-1:0] : b_victim;
    assign b_evict   = b_fill && b_valid_ways[b_victim] && b_dirty_ways[b_victim];
    assign b_mw      = b_noalloc || (b_write && !r_wb);
    assign n_clock   = r_clock + sacc_pkg::STAMP_W'(1);
    assign n_hits    = r_hits + sacc_pkg::COUNT_W'(look.hit);

    // line number of the victim: its tag above the set index
    assign b_victim_line = ((sacc_pkg::ADDR_W'(r_tag_row[b_victim]) << TAG_SHIFT)
                           | (sacc_pkg::ADDR_W'(b_set) << OFFSET_BITS)) >> OFFSET_BITS;

    always_comb begin
        n_tag_row          = r_tag_row;
        n_stamp_row        = r_stamp_row;
        n_tag_row[b_way]   = b_tag;
        n_stamp_row[b_way] = n_clock;
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tag_row   <= r_tag_mem[in_set];
            r_stamp_row <= r_stamp_mem[in_set];
        end
        if (b_fire && !b_noalloc) begin
            r_tag_mem[b_set]   <= n_tag_row;
            r_stamp_mem[b_set] <= n_stamp_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= i_operation;
            r_addr <= i_address;
            r_word <= i_write_word;
        end
        if (b_fire) begin
            r_hit         <= look.hit;
            r_way_used    <= b_noalloc ? '0 : sacc_pkg::WAY_OUT_W'(b_way);
            r_line_offset <= r_addr[sacc_pkg::LINE_OFF_OUT_W-1:0];
            r_evict       <= b_evict;
            r_evict_addr  <= b_evict ? b_victim_line[sacc_pkg::LINE_ADDR_OUT_W-1:0] : '0;
            r_fill        <= b_fill;
            r_mw          <= b_mw;
            r_mw_addr     <= b_mw ? r_addr : '0;
            r_mw_data     <= b_mw ? r_word : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa        <= 1'b1;
            r_wb        <= 1'b1;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_clock     <= '0;
            r_hits      <= '0;
            for (int s = 0; s < SETS; s++) begin
                r_valid[s] <= '0;
                r_dirty[s] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sacc_pkg::CFG_WRITE_ALLOCATE: r_wa <= i_cfg_data[0];
                    sacc_pkg::CFG_WRITE_BACK:     r_wb <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (in_fire) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end

            if (b_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (b_fire) begin
                r_hits <= n_hits;
                if (!b_noalloc) begin
                    r_clock               <= n_clock;
                    r_valid[b_set][b_way] <= 1'b1;
                    if (b_write && r_wb) begin
                        r_dirty[b_set][b_way] <= 1'b1;
                    end else if (b_fill) begin
                        r_dirty[b_set][b_way] <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_valid              = r_out_valid;
    assign o_hit                = r_hit;
    assign o_way_used           = r_way_used;
    assign o_line_offset        = r_line_offset;
    assign o_evict              = r_evict;
    assign o_evict_line_address = r_evict_addr;
    assign o_fill               = r_fill;
    assign o_mem_write          = r_mw;
    assign o_mem_write_address  = r_mw_addr;
    assign o_mem_write_data     = r_mw_data;
    assign o_hit_count          = r_hits;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_b_valid)
        else $error("access accepted but not held in flight");

    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && (o_fill || o_evict)))
        else $error("hit reported with fill or eviction");

    a_evict_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evict) |-> o_fill)
        else $error("eviction without line fill");

    a_hits_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |=> (r_hits == $past(r_hits))
                      || (r_hits == $past(r_hits) + sacc_pkg::COUNT_W'(1)))
        else $error("hit count moved by more than one");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && r_b_valid) |=> $stable(r_clock) && r_b_valid)
        else $error("set state updated while result stalled");

endmodule

@@ rtl/sacc_lookup.sv @@
`timescale 1ns / 1ps

module sacc_lookup #(
    parameter int WAYS  = sacc_pkg::DEF_WAYS,
    parameter int TAG_W = 24
) (
    input  logic [WAYS-1:0][TAG_W-1:0]             i_tags,
    input  logic [WAYS-1:0][sacc_pkg::STAMP_W-1:0] i_stamps,
    input  logic [WAYS-1:0]                        i_valid_ways,
    input  logic [TAG_W-1:0]                       i_tag,
    output sacc_pkg::t_lookup                      o_look
);

    localparam int LVLS = (WAYS > 1) ? $clog2(WAYS) : 0;
    localparam int P    = 1 << LVLS;

    logic [sacc_pkg::STAMP_W-1:0]   node_stamp [1:2*P-1];
    logic [sacc_pkg::WAY_IDX_W-1:0] node_idx   [1:2*P-1];
    logic                           node_ok    [1:2*P-1];

    logic                           hit;
    logic [sacc_pkg::WAY_IDX_W-1:0] hit_way;
    logic                           any_free;
    logic [sacc_pkg::WAY_IDX_W-1:0] free_way;

    // lowest matching way and lowest invalid way
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        any_free = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_valid_ways[w] && (i_tags[w] == i_tag)) begin
                hit     = 1'b1;
                hit_way = sacc_pkg::WAY_IDX_W'(w);
            end
            if (!i_valid_ways[w]) begin
                any_free = 1'b1;
                free_way = sacc_pkg::WAY_IDX_W'(w);
            end
        end
    end

    // min-stamp tree, left child wins ties so the lowest way is kept
    for (genvar j = 0; j < P; j++) begin : g_leaf
        if (j < WAYS) begin : g_real
            assign node_stamp[P+j] = i_stamps[j];
            assign node_idx[P+j]   = sacc_pkg::WAY_IDX_W'(j);
            assign node_ok[P+j]    = 1'b1;
        end else begin : g_pad
            assign node_stamp[P+j] = '0;
            assign node_idx[P+j]   = '0;
            assign node_ok[P+j]    = 1'b0;
        end
    end

    for (genvar i = 1; i < P; i++) begin : g_node
        logic take_left;
        assign take_left = node_ok[2*i] &&
                           (!node_ok[2*i+1] || (node_stamp[2*i] <= node_stamp[2*i+1]));
        assign node_stamp[i] = take_left ? node_stamp[2*i] : node_stamp[2*i+1];
        assign node_idx[i]   = take_left ? node_idx[2*i]   : node_idx[2*i+1];
        assign node_ok[i]    = node_ok[2*i] || node_ok[2*i+1];
    end

    assign o_look.hit        = hit;
    assign o_look.hit_way    = hit_way;
    assign o_look.victim_way = any_free ? free_way : node_idx[1];

endmodule

@@ bench/access_checker.sv @@
`timescale 1ns / 1ps

module access_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // access channel
    input  logic                                  i_acc_valid,
    input  logic                                  i_acc_ready,
    input  logic                                  i_operation,
    input  logic [sacc_pkg::ADDR_W-1:0]           i_address,
    input  logic [sacc_pkg::WORD_W-1:0]           i_write_word,
    // register writes
    input  logic                                  i_cfg_we,
    input  logic [sacc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sacc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // result channel
    input  logic                                  i_res_valid,
    input  logic                                  i_res_ready,
    input  logic                                  i_hit,
    input  logic [sacc_pkg::WAY_OUT_W-1:0]        i_way_used,
    input  logic [sacc_pkg::LINE_OFF_OUT_W-1:0]   i_line_offset,
    input  logic                                  i_evict,
    input  logic [sacc_pkg::LINE_ADDR_OUT_W-1:0]  i_evict_line_address,
    input  logic                                  i_fill,
    input  logic                                  i_mem_write,
    input  logic [sacc_pkg::ADDR_W-1:0]           i_mem_write_address,
    input  logic [sacc_pkg::WORD_W-1:0]           i_mem_write_data,
    input  logic [sacc_pkg::COUNT_W-1:0]          i_hit_count,
    // status for the bench top
    output logic [31:0]                           o_fail_count,
    output logic [31:0]                           o_pending,
    output logic [31:0]                           o_results,
    output logic [31:0]                           o_hits,
    output logic [31:0]                           o_evicts,
    output logic [31:0]                           o_bypass
);

    localparam int WAYS     = sacc_pkg::DEF_WAYS;
    localparam int OFF_BITS = sacc_pkg::DEF_OFFSET_BITS;
    localparam int IDX_BITS = sacc_pkg::DEF_INDEX_BITS;
    localparam int LINES    = WAYS << IDX_BITS;
    localparam int TAG_LSB  = OFF_BITS + IDX_BITS;
    localparam int TAG_W    = sacc_pkg::ADDR_W - TAG_LSB;

    typedef struct packed {
        logic                                 hit;
        logic [sacc_pkg::WAY_OUT_W-1:0]       way_used;
        logic [sacc_pkg::LINE_OFF_OUT_W-1:0]  line_offset;
        logic                                 evict;
        logic [sacc_pkg::LINE_ADDR_OUT_W-1:0] evict_line_address;
        logic                                 fill;
        logic                                 mem_write;
        logic [sacc_pkg::ADDR_W-1:0]          mem_write_address;
        logic [sacc_pkg::WORD_W-1:0]          mem_write_data;
        logic [sacc_pkg::COUNT_W-1:0]         hit_count;
    } t_access_result;

    // shadow of the tag array and the replacement state
    logic [TAG_W-1:0]             line_tag   [LINES];
    logic [sacc_pkg::STAMP_W-1:0] line_stamp [LINES];
    bit                           line_valid [LINES];
    bit                           line_dirty [LINES];
    logic [sacc_pkg::STAMP_W-1:0] use_clock;
    logic [sacc_pkg::COUNT_W-1:0] hits_total;
    bit                           alloc_on_write;
    bit                           write_back;

    t_access_result expected_results[$];
    int fail_cnt, result_cnt, hit_cnt, evict_cnt, bypass_cnt;

    initial begin
        fail_cnt     = 0;
        result_cnt   = 0;
        hit_cnt      = 0;
        evict_cnt    = 0;
        bypass_cnt   = 0;
        o_fail_count = '0;
        o_pending    = '0;
        o_results    = '0;
        o_hits       = '0;
        o_evicts     = '0;
        o_bypass     = '0;
    end

    function automatic t_access_result predict_access(
        input logic                         op,
        input logic [sacc_pkg::ADDR_W-1:0] addr,
        input logic [sacc_pkg::WORD_W-1:0] word);
        t_access_result r;
        logic [TAG_W-1:0] tag;
        int base, way, e, w;
        bit found;
        r     = '0;
        tag   = addr[sacc_pkg::ADDR_W-1:TAG_LSB];
        base  = addr[TAG_LSB-1:OFF_BITS] * WAYS;
        found = 1'b0;
        way   = 0;
        for (w = 0; w < WAYS; w++) begin
            if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
                found = 1'b1;
                way   = w;
            end
        end
        if (found) begin
            hits_total = hits_total + sacc_pkg::COUNT_W'(1);
            r.hit      = 1'b1;
        end
        if (!found && op == sacc_pkg::OP_WRITE && !alloc_on_write) begin
            // write goes around the cache, replacement state untouched
            r.mem_write         = 1'b1;
            r.mem_write_address = addr;
            r.mem_write_data    = word;
        end else begin
            if (!found) begin
                way = -1;
                for (w = 0; w < WAYS; w++)
                    if (way < 0 && !line_valid[base + w]) way = w;
                if (way < 0) begin
                    way = 0;
                    for (w = 1; w < WAYS; w++)
                        if (line_stamp[base + w] < line_stamp[base + way]) way = w;
                end
                e = base + way;
                if (line_valid[e] && line_dirty[e]) begin
                    r.evict              = 1'b1;
                    r.evict_line_address = {line_tag[e], addr[TAG_LSB-1:OFF_BITS]};
                end
                line_tag[e]   = tag;
                line_valid[e] = 1'b1;
                line_dirty[e] = 1'b0;
                r.fill        = 1'b1;
            end
            e             = base + way;
            use_clock     = use_clock + sacc_pkg::STAMP_W'(1);
            line_stamp[e] = use_clock;
            if (op == sacc_pkg::OP_WRITE) begin
                if (write_back) begin
                    line_dirty[e] = 1'b1;
                end else begin
                    r.mem_write         = 1'b1;
                    r.mem_write_address = addr;
                    r.mem_write_data    = word;
                end
            end
        end
        r.way_used    = way[sacc_pkg::WAY_OUT_W-1:0];
        r.line_offset = addr[sacc_pkg::LINE_OFF_OUT_W-1:0];
        r.hit_count   = hits_total;
        return r;
    endfunction

    function automatic string describe(input t_access_result r);
        return $sformatf({"hit=%0d way=%0d off=%h evict=%0d ela=%h fill=%0d",
                          " mw=%0d mwa=%h mwd=%h hc=%0d"},
                         r.hit, r.way_used, r.line_offset, r.evict, r.evict_line_address,
                         r.fill, r.mem_write, r.mem_write_address, r.mem_write_data,
                         r.hit_count);
    endfunction

    always @(posedge i_clk) begin : watch
        t_access_result exp_r;
        t_access_result got_r;
        int i;
        if (!i_rst_n) begin
            for (i = 0; i < LINES; i++) begin
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
            end
            use_clock      = '0;
            hits_total     = '0;
            alloc_on_write = 1'b1;
            write_back     = 1'b1;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got_r = '{i_hit, i_way_used, i_line_offset, i_evict, i_evict_line_address,
                          i_fill, i_mem_write, i_mem_write_address, i_mem_write_data,
                          i_hit_count};
                result_cnt++;
                if (expected_results.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result word: %s", describe(got_r));
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r !== exp_r) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("result %0d mismatch", result_cnt);
                            $display("  expected %s", describe(exp_r));
                            $display("  actual   %s", describe(got_r));
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == sacc_pkg::CFG_WRITE_ALLOCATE)
                    alloc_on_write = i_cfg_data[0];
                else if (i_cfg_index == sacc_pkg::CFG_WRITE_BACK)
                    write_back = i_cfg_data[0];
            end
            if (i_acc_valid && i_acc_ready) begin
                exp_r = predict_access(i_operation, i_address, i_write_word);
                if (exp_r.hit) hit_cnt++;
                if (exp_r.evict) evict_cnt++;
                if (!exp_r.hit && !exp_r.fill) bypass_cnt++;
                expected_results.push_back(exp_r);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_cnt;
        o_results    <= result_cnt;
        o_hits       <= hit_cnt;
        o_evicts     <= evict_cnt;
        o_bypass     <= bypass_cnt;
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_valid = 1'b0;
    logic                                 i_operation = sacc_pkg::OP_READ;
    logic [sacc_pkg::ADDR_W-1:0]          i_address = '0;
    logic [sacc_pkg::WORD_W-1:0]          i_write_word = '0;
    logic                                 i_cfg_we = 1'b0;
    logic [sacc_pkg::CFG_IDX_W-1:0]       i_cfg_index = sacc_pkg::CFG_WRITE_ALLOCATE;
    logic [sacc_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                                 i_ready = 1'b1;

    logic                                 o_ready;
    logic                                 o_valid;
    logic                                 o_hit;
    logic [sacc_pkg::WAY_OUT_W-1:0]       o_way_used;
    logic [sacc_pkg::LINE_OFF_OUT_W-1:0]  o_line_offset;
    logic                                 o_evict;
    logic [sacc_pkg::LINE_ADDR_OUT_W-1:0] o_evict_line_address;
    logic                                 o_fill;
    logic                                 o_mem_write;
    logic [sacc_pkg::ADDR_W-1:0]          o_mem_write_address;
    logic [sacc_pkg::WORD_W-1:0]          o_mem_write_data;
    logic [sacc_pkg::COUNT_W-1:0]         o_hit_count;

    logic [31:0] fail_count, pending, result_total, hit_total, evict_total, bypass_total;

    bit calm = 1'b0;
    int stall_left = 0;
    logic [23:0] tag_pool [6];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    set_assoc_cache_controller uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_operation          (i_operation),
        .i_address            (i_address),
        .i_write_word         (i_write_word),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_hit                (o_hit),
        .o_way_used           (o_way_used),
        .o_line_offset        (o_line_offset),
        .o_evict              (o_evict),
        .o_evict_line_address (o_evict_line_address),
        .o_fill               (o_fill),
        .o_mem_write          (o_mem_write),
        .o_mem_write_address  (o_mem_write_address),
        .o_mem_write_data     (o_mem_write_data),
        .o_hit_count          (o_hit_count)
    );

    access_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_acc_valid          (i_valid),
        .i_acc_ready          (o_ready),
        .i_operation          (i_operation),
        .i_address            (i_address),
        .i_write_word         (i_write_word),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_res_valid          (o_valid),
        .i_res_ready          (i_ready),
        .i_hit                (o_hit),
        .i_way_used           (o_way_used),
        .i_line_offset        (o_line_offset),
        .i_evict              (o_evict),
        .i_evict_line_address (o_evict_line_address),
        .i_fill               (o_fill),
        .i_mem_write          (o_mem_write),
        .i_mem_write_address  (o_mem_write_address),
        .i_mem_write_data     (o_mem_write_data),
        .i_hit_count          (o_hit_count),
        .o_fail_count         (fail_count),
        .o_pending            (pending),
        .o_results            (result_total),
        .o_hits               (hit_total),
        .o_evicts             (evict_total),
        .o_bypass             (bypass_total)
    );

    // result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            i_ready    <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= int'($urandom_range(1, 10));
            i_ready    <= 1'b0;
        end
    end

    function automatic logic [sacc_pkg::ADDR_W-1:0] line_addr(input logic [23:0] tag,
                                                              input logic [3:0] set,
                                                              input logic [3:0] off);
        return {tag, set, off};
    endfunction

    // returns at the edge where the word was taken; valid stays high
    task automatic send_access(input logic op, input logic [sacc_pkg::ADDR_W-1:0] addr,
                               input logic [sacc_pkg::WORD_W-1:0] word);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_address    <= addr;
        i_write_word <= word;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic random_access();
        logic [3:0] set;
        logic [sacc_pkg::ADDR_W-1:0] addr;
        if ($urandom_range(0, 6) == 0) begin
            addr = $urandom;
        end else begin
            set  = 4'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 15));
            addr = line_addr(tag_pool[$urandom_range(0, 5)], set,
                             4'($urandom_range(0, 15)));
        end
        send_access(1'($urandom_range(0, 1)), addr, $urandom);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_modes(input logic alloc, input logic wback);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sacc_pkg::CFG_WRITE_ALLOCATE;
        i_cfg_data  <= alloc;
        @(posedge i_clk);
        i_cfg_index <= sacc_pkg::CFG_WRITE_BACK;
        i_cfg_data  <= wback;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [1:0] modes [5];
        int p, k;
        modes[0] = 2'b11;
        modes[1] = 2'b01;
        modes[2] = 2'b10;
        modes[3] = 2'b00;
        modes[4] = 2'b11;
        tag_pool[0] = 24'h000000;
        tag_pool[1] = 24'hFFFFFF;
        for (k = 2; k < 6; k++) tag_pool[k] = 24'($urandom);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // allocate + write-back, as after reset
        send_access(sacc_pkg::OP_READ,  32'h0000_0000, 32'h1234_5678);
        send_access(sacc_pkg::OP_READ,  32'h0000_000F, 32'h0);
        send_access(sacc_pkg::OP_WRITE, 32'h0000_0004, 32'hFFFF_FFFF);
        send_access(sacc_pkg::OP_READ,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_access(sacc_pkg::OP_WRITE, 32'hFFFF_FFF0, 32'h0);
        // fill all ways of set 1 dirty, then force LRU victims out
        for (k = 1; k <= 4; k++)
            send_access(sacc_pkg::OP_WRITE, line_addr(24'h100 + 24'(k), 4'd1, 4'(k)),
                        $urandom);
        send_access(sacc_pkg::OP_READ, line_addr(24'h101, 4'd1, 4'd0), 32'h0);
        send_access(sacc_pkg::OP_READ, line_addr(24'h105, 4'd1, 4'd3), 32'h0);
        send_access(sacc_pkg::OP_READ, line_addr(24'h102, 4'd1, 4'd5), 32'h0);
        send_access(sacc_pkg::OP_READ, line_addr(24'h106, 4'd1, 4'd7), 32'h0);
        send_access(sacc_pkg::OP_READ, line_addr(24'h101, 4'd1, 4'd9), 32'h0);
        // victim is a clean line now
        send_access(sacc_pkg::OP_READ, line_addr(24'h107, 4'd1, 4'd2), 32'h0);
        drain();

        // no-allocate, write-through
        set_modes(1'b0, 1'b0);
        send_access(sacc_pkg::OP_WRITE, line_addr(24'hABCDEF, 4'd2, 4'd6), 32'hDEAD_BEEF);
        send_access(sacc_pkg::OP_READ,  line_addr(24'hABCDEF, 4'd2, 4'd6), 32'h0);
        send_access(sacc_pkg::OP_WRITE, line_addr(24'hABCDEF, 4'd2, 4'd8), 32'hA5A5_5A5A);
        send_access(sacc_pkg::OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        for (p = 0; p < 5; p++) begin
            set_modes(modes[p][1], modes[p][0]);
            if (p == 4) calm <= 1'b1;
            for (k = 0; k < 80; k++) random_access();
            drain();
        end

        $display("%0d accesses checked over five mode settings plus directed cases",
                 result_total);
        $display("hits %0d, dirty evictions %0d, no-allocate write misses %0d",
                 hit_total, evict_total, bypass_total);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("timeout with %0d words outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
